// ----- src/tplm_pkg.sv -----
// Shared types and constants for the two-level page table map/lookup block.
// No dependencies; used by tplm_walk, the top module and the testbench.
package tplm_pkg;

    // Fixed geometry of the 32-bit two-level layout
    localparam int DIR_ENTRIES    = 1024;
    localparam int DIR_AW         = 10;
    localparam int TABLE_ENTRIES  = 1024;
    localparam int TABLE_AW       = 10;
    localparam int OFFSET_W       = 12;
    localparam int FRAME_W        = 20;
    localparam int FLAGS_W        = 12;
    localparam int NUM_TABLES_DEF = 16;

    // Entry attribute bits
    localparam logic [31:0] ENTRY_PRESENT = 32'h0000_0001;
    localparam logic [31:0] ENTRY_WRITE   = 32'h0000_0002;

    // Item actions
    localparam logic ACT_MAP    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [1:0] ST_OVERWRITE  = 2'd2;
    localparam logic [1:0] ST_NO_TABLE   = 2'd3;

    // Configuration port geometry: one register, word index in paddr[2]
    localparam int   CFG_AW        = 3;
    localparam logic REG_POOL_BASE = 1'b0;

    typedef struct packed {
        logic               action;
        logic [31:0]        virt_addr;
        logic [31:0]        phys_addr;
        logic [FLAGS_W-1:0] flags;
    } in_t;

    typedef struct packed {
        logic [31:0] result_addr;
        logic [1:0]  status;
    } out_t;

endpackage

// ----- src/tplm_ram.sv -----
// Synchronous RAM, one write port and one read port, registered read data.
// Depends on nothing; instantiated for the directory and the page table pool.
module tplm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/tplm_walk.sv -----
// Walk engine: directory and page table pool memories, clearing sweep,
// and the map/lookup sequencer. Depends on tplm_pkg and tplm_ram.
module tplm_walk
    import tplm_pkg::*;
#(
    parameter int NUM_TABLES = NUM_TABLES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FRAME_W-1:0] table_pool_base,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_t                in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_t               out_data
);

    localparam int SLOT_W    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int CNT_W     = $clog2(NUM_TABLES + 1);
    localparam int PTE_DEPTH = NUM_TABLES * TABLE_ENTRIES;
    localparam int PTE_AW    = $clog2(PTE_DEPTH);
    localparam int DIR_W     = 32 + SLOT_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_DIR   = 2'd2;
    localparam logic [1:0] S_PAGE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [PTE_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]  next_free_reg, next_free_next;
    in_t               item_reg, item_next;
    logic [PTE_AW-1:0] pte_addr_reg, pte_addr_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_data_reg, out_data_next;

    // memory ports
    logic              dir_we, dir_re;
    logic [DIR_AW-1:0] dir_waddr, dir_raddr;
    logic [DIR_W-1:0]  dir_wdata, dir_rdata;
    logic              pte_we, pte_re;
    logic [PTE_AW-1:0] pte_waddr, pte_raddr;
    logic [31:0]       pte_wdata, pte_rdata;

    // decode helpers
    logic               accept, out_free, load_out;
    logic               dir_present, need_new, pool_empty;
    logic [SLOT_W-1:0]  dir_slot, new_slot, use_slot;
    logic [DIR_AW-1:0]  item_di;
    logic [TABLE_AW-1:0] item_ti;
    logic [FRAME_W-1:0] table_pfn;
    out_t               result;

    tplm_ram #(
        .WIDTH (DIR_W),
        .DEPTH (DIR_ENTRIES)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (dir_raddr),
        .rdata (dir_rdata)
    );

    tplm_ram #(
        .WIDTH (32),
        .DEPTH (PTE_DEPTH)
    ) u_pte_ram (
        .clk   (clk),
        .we    (pte_we),
        .waddr (pte_waddr),
        .wdata (pte_wdata),
        .re    (pte_re),
        .raddr (pte_raddr),
        .rdata (pte_rdata)
    );

    // handshake: a new word enters when idle or while the page step retires
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) || ((state_reg == S_PAGE) && out_free));
    assign accept   = in_valid && !in_stall;

    // directory step decode
    assign item_di     = item_reg.virt_addr[31:22];
    assign item_ti     = item_reg.virt_addr[21:12];
    assign dir_present = dir_rdata[0];
    assign dir_slot    = dir_rdata[DIR_W-1 -: SLOT_W];
    assign new_slot    = next_free_reg[SLOT_W-1:0];
    assign pool_empty  = (next_free_reg >= CNT_W'(NUM_TABLES));
    assign need_new    = (item_reg.action == ACT_MAP) && !dir_present;
    assign use_slot    = need_new ? new_slot : dir_slot;
    assign table_pfn   = FRAME_W'(table_pool_base + FRAME_W'(new_slot));

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        next_free_next = next_free_reg;
        item_next      = item_reg;
        pte_addr_next  = pte_addr_reg;
        out_data_next  = out_data_reg;
        load_out       = 1'b0;
        result         = '0;

        dir_we    = 1'b0;
        dir_waddr = item_di;
        dir_wdata = '0;
        dir_re    = 1'b0;
        dir_raddr = in_data.virt_addr[31:22];
        pte_we    = 1'b0;
        pte_waddr = pte_addr_reg;
        pte_wdata = '0;
        pte_re    = 1'b0;
        pte_raddr = PTE_AW'({use_slot, item_ti});

        // directory read for an incoming word
        if (accept)
        begin
            dir_re    = 1'b1;
            item_next = in_data;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero both memories, one address a cycle
                dir_we    = 1'b1;
                dir_waddr = clr_addr_reg[DIR_AW-1:0];
                pte_we    = 1'b1;
                pte_waddr = clr_addr_reg;
                if (clr_addr_reg == PTE_AW'(PTE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DIR;
                end
            end
            S_DIR:
            begin
                if ((item_reg.action == ACT_LOOKUP) && !dir_present)
                begin
                    result.status = ST_NOT_MAPPED;
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (need_new && pool_empty)
                begin
                    result.status = ST_NO_TABLE;
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // page table read; install a fresh pool table if needed
                    pte_re        = 1'b1;
                    pte_addr_next = PTE_AW'({use_slot, item_ti});
                    if (need_new)
                    begin
                        dir_we         = 1'b1;
                        dir_wdata      = {use_slot, ({table_pfn, {OFFSET_W{1'b0}}}
                                          | ENTRY_PRESENT | ENTRY_WRITE
                                          | {20'd0, item_reg.flags})};
                        next_free_next = next_free_reg + 1'b1;
                    end
                    state_next = S_PAGE;
                end
            end
            S_PAGE:
            begin
                if (item_reg.action == ACT_MAP)
                begin
                    result.status = (pte_rdata != 32'd0) ? ST_OVERWRITE : ST_OK;
                end
                else if (pte_rdata[0])
                begin
                    result.result_addr = {pte_rdata[31:12], item_reg.virt_addr[11:0]};
                    result.status      = ST_OK;
                end
                else
                begin
                    result.status = ST_NOT_MAPPED;
                end
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (item_reg.action == ACT_MAP)
                    begin
                        pte_we    = 1'b1;
                        pte_wdata = {item_reg.phys_addr[31:12], {OFFSET_W{1'b0}}}
                                    | ENTRY_PRESENT | ENTRY_WRITE
                                    | {20'd0, item_reg.flags};
                    end
                    state_next = accept ? S_DIR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_data_next = result;
        end
    end

    // output register
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            next_free_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            next_free_reg <= next_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        pte_addr_reg <= pte_addr_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/two_level_page_table_map_lookup.sv -----
// A result word for a directory miss or an empty pool is registered from the
// directory step, and for a full two-level walk from the page step.
// A new word is accepted only while idle or as the previous page step retires,
// since the directory read precedes the page table read on the synchronous RAMs.
// Reset clears both memories in a sweep of NUM_TABLES*1024 addresses,
// with in_stall high meanwhile. Depends on tplm_pkg and tplm_walk.
module two_level_page_table_map_lookup
    import tplm_pkg::*;
#(
    parameter int NUM_TABLES = NUM_TABLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data
);

    logic [FRAME_W-1:0] pool_base_reg, pool_base_next;
    logic               cfg_write;

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        pool_base_next = pool_base_reg;
        if (cfg_write && (paddr[2] == REG_POOL_BASE))
        begin
            pool_base_next = pwdata[FRAME_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
        end
        else
        begin
            pool_base_reg <= pool_base_next;
        end
    end

    // read back
    assign prdata = (paddr[2] == REG_POOL_BASE) ? {{(32-FRAME_W){1'b0}}, pool_base_reg}
                                                : 32'd0;

    tplm_walk #(
        .NUM_TABLES (NUM_TABLES)
    ) u_walk (
        .clk             (clk),
        .rst_n           (rst_n),
        .table_pool_base (pool_base_reg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data)
    );

endmodule

// ----- verif/tb.sv -----
// Testbench for two_level_page_table_map_lookup: directed and random map/lookup words
// checked against an in-bench page walk predictor, with APB writes of the pool base.
// Depends on tplm_pkg and the RTL under src.
module tb;
    import tplm_pkg::*;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int RANDOM_PER_PHASE = 280;
    localparam int PT_AW = $clog2(NUM_TABLES_DEF*TABLE_ENTRIES);
    localparam logic [CFG_AW-1:0] POOL_BASE_ADDR = {REG_POOL_BASE, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;

    // Predictor state: directory, slots, pool tables, allocation pointer
    logic [31:0] pd_entry [DIR_ENTRIES];
    logic [3:0]  pd_slot [DIR_ENTRIES];
    logic [31:0] pt_entry [NUM_TABLES_DEF*TABLE_ENTRIES];
    int          tables_used = 0;
    logic [FRAME_W-1:0] pool_base = '0;

    // Stimulus bookkeeping
    logic [DIR_AW-1:0]  dirs_in_use [$];
    logic [FRAME_W-1:0] mapped_pages [$];
    out_t        pending_results [$];
    int          mismatches = 0;
    int          send_idle_pct = 17;
    int          recv_idle_pct = 70;
    int          hold_request = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    two_level_page_table_map_lookup i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Walk both levels for one word and apply its side effects
    function automatic out_t walk_tables(input in_t w);
        logic [DIR_AW-1:0]   di;
        logic [TABLE_AW-1:0] ti;
        logic [31:0]         tbl_addr;
        logic [31:0]         pte;
        logic [PT_AW-1:0]    idx;
        out_t                r;
        di = w.virt_addr[31:22];
        ti = w.virt_addr[21:12];
        r.result_addr = '0;
        r.status = ST_OK;
        if (w.action == ACT_MAP)
        begin
            if ((pd_entry[di] & ENTRY_PRESENT) == 0)
            begin
                if (tables_used >= NUM_TABLES_DEF)
                begin
                    r.status = ST_NO_TABLE;
                    return r;
                end
                // 20-bit frame add wraps exactly like the 32-bit shift
                tbl_addr = {pool_base + FRAME_W'(tables_used), 12'h000};
                for (int k = 0; k < TABLE_ENTRIES; k++)
                    pt_entry[tables_used*TABLE_ENTRIES + k] = '0;
                pd_entry[di] = tbl_addr | ENTRY_PRESENT | ENTRY_WRITE | {20'b0, w.flags};
                pd_slot[di] = tables_used[3:0];
                tables_used++;
                dirs_in_use.push_back(di);
            end
            idx = {pd_slot[di], ti};
            r.status = (pt_entry[idx] != 0) ? ST_OVERWRITE : ST_OK;
            pt_entry[idx] = {w.phys_addr[31:12], 12'h000} | ENTRY_PRESENT | ENTRY_WRITE
                            | {20'b0, w.flags};
            mapped_pages.push_back(w.virt_addr[31:12]);
        end
        else
        begin
            if ((pd_entry[di] & ENTRY_PRESENT) == 0)
                r.status = ST_NOT_MAPPED;
            else
            begin
                pte = pt_entry[{pd_slot[di], ti}];
                if ((pte & ENTRY_PRESENT) == 0)
                    r.status = ST_NOT_MAPPED;
                else
                    r.result_addr = {pte[31:12], 12'h000} + {20'b0, w.virt_addr[11:0]};
            end
        end
        return r;
    endfunction

    function automatic in_t make_word(input logic act, input logic [31:0] va,
                                      input logic [31:0] pa, input logic [11:0] fl);
        in_t w;
        w.action = act;
        w.virt_addr = va;
        w.phys_addr = pa;
        w.flags = fl;
        return w;
    endfunction

    // Mostly hits on live tables and pages, with a share of fresh directories
    function automatic in_t random_word();
        in_t         w;
        int unsigned pick;
        w.action = ($urandom_range(1) == 1) ? ACT_LOOKUP : ACT_MAP;
        w.virt_addr = $urandom;
        w.phys_addr = $urandom;
        w.flags = FLAGS_W'($urandom_range(12'hFFF));
        pick = $urandom_range(99);
        if (w.action == ACT_LOOKUP && mapped_pages.size() != 0 && pick < 60)
            w.virt_addr[31:12] = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
        else
        begin
            if (dirs_in_use.size() != 0 && pick < 90)
                w.virt_addr[31:22] = dirs_in_use[$urandom_range(dirs_in_use.size() - 1)];
            pick = $urandom_range(99);
            if (pick < 40)
                w.virt_addr[21:12] = TABLE_AW'($urandom_range(3));
            else if (pick < 50)
                w.virt_addr[21:12] = 10'h3FF;
        end
        return w;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("tb: mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // Offer one word, hold it until accepted, then record its expected result
    task automatic send_word(input in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(walk_tables(w));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // room for the walk to settle
        repeat (4) @(posedge clk);
    endtask

    // APB write of the pool base, then a read back of the same register
    task automatic write_pool_base(input logic [FRAME_W-1:0] base);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= POOL_BASE_ADDR;
        pwdata  <= {12'b0, base};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        pool_base = base;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {12'b0, base})
            note_mismatch("pool base read", {12'b0, base}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Empty directory, first table, full-range fields, overwrite and offset add
    task automatic test_single_pages();
        send_word(make_word(ACT_LOOKUP, 32'h0000_0000, 32'h0, 12'h000));
        send_word(make_word(ACT_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
        send_word(make_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h000));
        send_word(make_word(ACT_MAP, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000));
        send_word(make_word(ACT_LOOKUP, 32'hFFFF_F000, 32'hFFFF_FFFF, 12'hFFF));
        send_word(make_word(ACT_LOOKUP, 32'hFFC0_0000, 32'h0, 12'h000));
        send_word(make_word(ACT_MAP, 32'h0000_0000, 32'h1234_5FFF, 12'h004));
        send_word(make_word(ACT_LOOKUP, 32'h0000_0ABC, 32'h0, 12'h000));
        wait_drained();
    endtask

    // Top-of-range base makes later tables wrap; then run the pool dry
    task automatic test_pool_exhaustion();
        write_pool_base(20'hFFFFF);
        for (int d = 1; d <= NUM_TABLES_DEF - 2; d++)
            send_word(make_word(ACT_MAP, {10'(d), 10'(d), 12'h000}, $urandom, 12'h000));
        send_word(make_word(ACT_MAP, {10'd500, 22'h0}, 32'hABCD_E000, 12'h000));
        send_word(make_word(ACT_LOOKUP, {10'd500, 22'h0}, 32'h0, 12'h000));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct,
                                       input logic [FRAME_W-1:0] base);
        write_pool_base(base);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n) send_word(random_word());
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, so the input backs up
    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 300;
        repeat (60) send_word(random_word());
        wait_drained();
    endtask

    // Result checker and receiver stall
    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                note_mismatch("unexpected word", 32'h0, out_data.result_addr);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.result_addr !== want.result_addr)
                    note_mismatch("result_addr", want.result_addr, out_data.result_addr);
                if (out_data.status !== want.status)
                    note_mismatch("status", {30'b0, want.status}, {30'b0, out_data.status});
            end
        end
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < DIR_ENTRIES; i++)
        begin
            pd_entry[i] = '0;
            pd_slot[i] = '0;
        end
        for (int i = 0; i < NUM_TABLES_DEF*TABLE_ENTRIES; i++)
            pt_entry[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        // clearing sweep runs with the input stalled
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);

        test_single_pages();
        test_pool_exhaustion();
        test_random_traffic(RANDOM_PER_PHASE, 17, 70, 20'h00000);
        test_random_traffic(RANDOM_PER_PHASE, 70, 17, FRAME_W'($urandom_range(20'hFFFFF)));
        test_output_hold_off();
        test_random_traffic(RANDOM_PER_PHASE, 0, 0, 20'h80000);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ----- two_level_page_table_map_lookup.f -----
src/tplm_pkg.sv
src/tplm_ram.sv
src/tplm_walk.sv
src/two_level_page_table_map_lookup.sv
verif/tb.sv
